// File: hw/rtl/kf1d_pkg.sv
// ----------------------------------------------------------------------------
// kf1d_pkg: shared types and constants of the scalar Kalman filter
// Payload structs, controller-to-datapath command and status, and the
// constant helpers used to build the reset values.
// ----------------------------------------------------------------------------
package kf1d_pkg;

    // Word width of every payload field and estimate value (signed Q16.16 by default).
    localparam int DW                = 32;
    localparam int FRAC_BITS_DEFAULT = 16;

    // One quotient bit is produced per divider step.
    localparam int DIV_STEPS = DW;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_VAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_VAR      = 1'b1;

    typedef struct packed {
        logic [DW-1:0] measurement;
        logic [DW-1:0] motion_step;
    } kf1d_in_t;

    typedef struct packed {
        logic [DW-1:0] posterior_mean;
        logic [DW-1:0] posterior_var;
        logic [DW-1:0] predicted_mean;
        logic [DW-1:0] predicted_var;
    } kf1d_out_t;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_MEAN = 2'd1,    // |estimate mean| * measurement variance
        MUL_MEAS = 2'd2,    // |measurement| * estimate variance
        MUL_VAR  = 2'd3     // estimate variance * measurement variance
    } mul_op_t;

    typedef struct packed {
        logic    load_input;
        mul_op_t mul_op;
        logic    combine;
        logic    div_step;
        logic    finish;
    } kf1d_cmd_t;

    typedef struct packed {
        logic div_last;
    } kf1d_status_t;

    // Clamp a double-width constant to the unsigned word range.
    function automatic logic [DW-1:0] sat_to_word(input logic [2*DW-1:0] x);
        logic [DW-1:0] r;
        if (x[2*DW-1:DW] != '0)
        begin
            r = '1;
        end
        else
        begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/kalman_filter_1d.sv
// ----------------------------------------------------------------------------
// kalman_filter_1d: scalar Kalman filter in signed fixed point
// Fuses each position measurement with the running estimate, then applies
// the motion step, and returns the posterior and predicted mean/variance.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  input     in         in_valid / in_stall   kf1d_in_t  (measurement, motion_step)
//  output    out        out_valid / out_stall kf1d_out_t (posterior and predicted pairs)
//  config    in         cfg_write             cfg_index, cfg_data
//
//  An item passes from its transfer through the mean, measurement and
//  variance products on the shared multiplier, the operand setup, 32 steps
//  of the two restoring dividers (one quotient bit per step) and the finish.
//  The next item is taken the cycle after the result is loaded, so the
//  filter takes no new item while one is in progress.
//  A result that is stalled at the output holds the finished computation in
//  its last step; the input stays stalled until the result register frees.
//  Reset loads the estimate (mean 0, variance 1000.0) and the default noise
//  variances; no clearing pass is needed.
//
module kalman_filter_1d #(
    parameter int FRAC_BITS = kf1d_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [kf1d_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kf1d_pkg::DW-1:0]        cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  kf1d_pkg::kf1d_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output kf1d_pkg::kf1d_out_t            out_data
);
    import kf1d_pkg::*;

    // Reset constants built at double width and clamped to the word, so a
    // wide fraction that would overflow saturates instead of wrapping.
    localparam logic [2*DW-1:0] ONE_WIDE        = (2*DW)'(1) << FRAC_BITS;
    localparam logic [2*DW-1:0] EST_VAR_WIDE    = ONE_WIDE * (2*DW)'(1000);
    localparam logic [2*DW-1:0] MEAS_VAR_WIDE   = ONE_WIDE * (2*DW)'(2);
    localparam logic [2*DW-1:0] MOTION_VAR_WIDE = (ONE_WIDE * (2*DW)'(3) + (2*DW)'(5))
                                                  / (2*DW)'(10);

    kf1d_cmd_t    cmd;
    kf1d_status_t status;

    // The controller owns sequencing and both handshakes; the datapath owns
    // every payload register and only acts on the command it is given.
    kf1d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    kf1d_datapath #(
        .EST_VAR_RESET    (sat_to_word(EST_VAR_WIDE)),
        .MEAS_VAR_RESET   (sat_to_word(MEAS_VAR_WIDE)),
        .MOTION_VAR_RESET (sat_to_word(MOTION_VAR_WIDE))
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: hw/rtl/kf1d_ctrl.sv
// ----------------------------------------------------------------------------
// kf1d_ctrl: sequencing state machine of the scalar Kalman filter
// Steps the datapath through three multiplies, the operand setup, the
// restoring divisions and the final prediction, and owns both handshakes.
// ----------------------------------------------------------------------------
module kf1d_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  kf1d_pkg::kf1d_status_t status,
    output kf1d_pkg::kf1d_cmd_t    cmd
);
    import kf1d_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_MUL_MEAN = 7'b0000010,
        S_MUL_MEAS = 7'b0000100,
        S_MUL_VAR  = 7'b0001000,
        S_COMBINE  = 7'b0010000,
        S_DIVIDE   = 7'b0100000,
        S_FINISH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.mul_op     = MUL_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_input = 1'b1;
                    state_next     = S_MUL_MEAN;
                end
            end
            S_MUL_MEAN:
            begin
                cmd.mul_op = MUL_MEAN;
                state_next = S_MUL_MEAS;
            end
            S_MUL_MEAS:
            begin
                cmd.mul_op = MUL_MEAS;
                state_next = S_MUL_VAR;
            end
            S_MUL_VAR:
            begin
                cmd.mul_op = MUL_VAR;
                state_next = S_COMBINE;
            end
            S_COMBINE:
            begin
                cmd.combine = 1'b1;
                state_next  = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/kf1d_datapath.sv
// ----------------------------------------------------------------------------
// kf1d_datapath: arithmetic and storage of the scalar Kalman filter
// Configuration registers, estimate state, one shared multiplier, two
// restoring dividers stepped together, the prediction adders and the
// result register.
// ----------------------------------------------------------------------------
module kf1d_datapath #(
    parameter logic [kf1d_pkg::DW-1:0] EST_VAR_RESET    = '0,
    parameter logic [kf1d_pkg::DW-1:0] MEAS_VAR_RESET   = '0,
    parameter logic [kf1d_pkg::DW-1:0] MOTION_VAR_RESET = '0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [kf1d_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kf1d_pkg::DW-1:0]              cfg_data,
    input  kf1d_pkg::kf1d_in_t                   in_data,
    output kf1d_pkg::kf1d_out_t                  out_data,
    input  kf1d_pkg::kf1d_cmd_t                  cmd,
    output kf1d_pkg::kf1d_status_t               status
);
    import kf1d_pkg::*;

    logic [DW-1:0]   meas_var_reg, motion_var_reg;
    logic [DW-1:0]   est_mean_reg, est_var_reg;
    logic [DW-1:0]   z_reg, u_reg;
    logic [2*DW-1:0] t1_reg, t2_reg, vr_reg;
    logic [DW:0]     divisor_reg;
    logic            zero_total_reg, neg_reg;
    logic [DW:0]     rem_a_reg, rem_b_reg;
    logic [DW-1:0]   quo_a_reg, quo_b_reg;
    logic [CNT_W-1:0] cnt_reg;
    kf1d_out_t       out_reg;

    logic            est_neg, z_neg;
    logic [DW-1:0]   est_mag, z_mag;
    logic [DW-1:0]   mul_a, mul_b;
    logic [2*DW-1:0] product;
    logic [DW:0]     total;
    logic [2*DW-1:0] sum;
    logic            sum_neg;
    logic [DW+1:0]   trial_a, trial_b, diff_a, diff_b;
    logic            ge_a, ge_b;
    logic [DW-1:0]   post_mean, post_var, pred_mean, pred_var;
    logic [DW:0]     mean_sum, var_sum;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_var_reg   <= MEAS_VAR_RESET;
            motion_var_reg <= MOTION_VAR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MEASUREMENT_VAR: meas_var_reg   <= cfg_data;
                REG_MOTION_VAR:      motion_var_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Sign and magnitude of the two signed operands.
    assign est_neg = est_mean_reg[DW-1];
    assign z_neg   = z_reg[DW-1];
    assign est_mag = est_neg ? (~est_mean_reg + DW'(1)) : est_mean_reg;
    assign z_mag   = z_neg ? (~z_reg + DW'(1)) : z_reg;

    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_MEAN:
            begin
                mul_a = est_mag;
                mul_b = meas_var_reg;
            end
            MUL_MEAS:
            begin
                mul_a = z_mag;
                mul_b = est_var_reg;
            end
            MUL_VAR:
            begin
                mul_a = est_var_reg;
                mul_b = meas_var_reg;
            end
            MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = {{DW{1'b0}}, mul_a} * {{DW{1'b0}}, mul_b};

    always_ff @(posedge clk)
    begin
        if (cmd.load_input)
        begin
            z_reg <= in_data.measurement;
            u_reg <= in_data.motion_step;
        end
        if (cmd.mul_op == MUL_MEAN)
        begin
            t1_reg <= product;
        end
        if (cmd.mul_op == MUL_MEAS)
        begin
            t2_reg <= product;
        end
        if (cmd.mul_op == MUL_VAR)
        begin
            vr_reg <= product;
        end
    end

    // Signed numerator from the two magnitude products.
    assign total = {1'b0, est_var_reg} + {1'b0, meas_var_reg};

    always_comb
    begin
        if (est_neg == z_neg)
        begin
            sum     = t1_reg + t2_reg;
            sum_neg = est_neg;
        end
        else if (t1_reg < t2_reg)
        begin
            sum     = t2_reg - t1_reg;
            sum_neg = z_neg;
        end
        else
        begin
            sum     = t1_reg - t2_reg;
            sum_neg = est_neg;
        end
    end

    // Restoring division steps. Both quotients are known to fit one word, so
    // the upper dividend half starts as the partial remainder.
    assign trial_a = {rem_a_reg, quo_a_reg[DW-1]};
    assign trial_b = {rem_b_reg, quo_b_reg[DW-1]};
    assign diff_a  = trial_a - {1'b0, divisor_reg};
    assign diff_b  = trial_b - {1'b0, divisor_reg};
    assign ge_a    = (trial_a >= {1'b0, divisor_reg});
    assign ge_b    = (trial_b >= {1'b0, divisor_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.combine)
        begin
            divisor_reg    <= total;
            zero_total_reg <= (total == '0);
            neg_reg        <= sum_neg;
            rem_a_reg      <= {1'b0, sum[2*DW-1:DW]};
            quo_a_reg      <= sum[DW-1:0];
            rem_b_reg      <= {1'b0, vr_reg[2*DW-1:DW]};
            quo_b_reg      <= vr_reg[DW-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_a_reg <= ge_a ? diff_a[DW:0] : trial_a[DW:0];
            quo_a_reg <= {quo_a_reg[DW-2:0], ge_a};
            rem_b_reg <= ge_b ? diff_b[DW:0] : trial_b[DW:0];
            quo_b_reg <= {quo_b_reg[DW-2:0], ge_b};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.combine)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign status.div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // Update result, with zero total variance passing the estimate through.
    always_comb
    begin
        if (zero_total_reg)
        begin
            post_mean = est_mean_reg;
            post_var  = '0;
        end
        else
        begin
            post_mean = neg_reg ? (~quo_a_reg + DW'(1)) : quo_a_reg;
            post_var  = quo_b_reg;
        end
    end

    // Saturating prediction.
    assign mean_sum = {post_mean[DW-1], post_mean} + {u_reg[DW-1], u_reg};
    assign var_sum  = {1'b0, post_var} + {1'b0, motion_var_reg};

    always_comb
    begin
        if (mean_sum[DW] != mean_sum[DW-1])
        begin
            pred_mean = mean_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
        else
        begin
            pred_mean = mean_sum[DW-1:0];
        end
        pred_var = var_sum[DW] ? '1 : var_sum[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_mean_reg <= '0;
            est_var_reg  <= EST_VAR_RESET;
        end
        else if (cmd.finish)
        begin
            est_mean_reg <= pred_mean;
            est_var_reg  <= pred_var;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.posterior_mean <= post_mean;
            out_reg.posterior_var  <= post_var;
            out_reg.predicted_mean <= pred_mean;
            out_reg.predicted_var  <= pred_var;
        end
    end

    assign out_data = out_reg;

endmodule
